>>> rtl/core/kse_pkg.sv
package kse_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int FIELD_BITS = 16;

   localparam int IDX_BITS       = $clog2(MAX_ITEMS);
   localparam int CNT_BITS       = $clog2(MAX_ITEMS + 1);
   localparam int GROUP_BITS     = 6;
   localparam int GROUP_MAP_BITS = 2 ** GROUP_BITS;
   localparam int SUM_BITS       = FIELD_BITS + IDX_BITS;
   localparam int LIMIT_BITS     = 22;
   localparam int TOTAL_BITS     = 22;
   localparam int ENTRY_BITS     = 3 * FIELD_BITS + GROUP_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 22;
   localparam int COUNT_REG_BITS = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITEM_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_LIMIT = 2'd2;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_EVALUATE = 1'b1;

   typedef struct packed {
      logic [GROUP_BITS-1:0] group;
      logic [FIELD_BITS-1:0] value;
      logic [FIELD_BITS-1:0] volume;
      logic [FIELD_BITS-1:0] weight;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

>>> rtl/core/kse_req_if.sv
interface kse_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [kse_pkg::IDX_BITS-1:0]     item_index;
   logic [kse_pkg::FIELD_BITS-1:0]   item_weight;
   logic [kse_pkg::FIELD_BITS-1:0]   item_volume;
   logic [kse_pkg::FIELD_BITS-1:0]   item_value;
   logic [kse_pkg::GROUP_BITS-1:0]   item_group;
   logic [kse_pkg::MAX_ITEMS-1:0]    selection_mask;

   modport source (
      output valid, operation, item_index, item_weight, item_volume, item_value,
             item_group, selection_mask,
      input  ready
   );

   modport sink (
      input  valid, operation, item_index, item_weight, item_volume, item_value,
             item_group, selection_mask,
      output ready
   );
endinterface

>>> rtl/core/kse_rsp_if.sv
interface kse_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             feasible;
   logic [kse_pkg::TOTAL_BITS-1:0]   total_value;

   modport source (
      output valid, feasible, total_value,
      input  ready
   );

   modport sink (
      input  valid, feasible, total_value,
      output ready
   );
endinterface

>>> rtl/core/knapsack_selection_evaluator.sv
// Knapsack selection evaluator.
// Requests arrive on req_bus. A load request (operation 0) writes one item
// table entry and returns nothing; it is taken only when idle. An evaluate
// request (operation 1) walks table entries 0..n-1, n = min(item_count, 64),
// one entry per cycle through the table memory's single read port, summing
// weight, volume and value of selected entries and building maps of groups
// present and groups required. One response on rsp_bus follows: feasible and
// total_value (zero when infeasible).
// An evaluate runs from idle through the run state (skipped for n = 0) to the
// finish state, which writes the response before the next request is taken.
// The response sits in an output register. While it waits, loads and one more
// evaluate are taken; that evaluate holds its result until the register frees.
// The user writes configuration on the csr_ port while the block is idle;
// the block does not enforce this. Reset (synchronous) clears control state
// and sets item_count 1 and both limits 0; table contents stay undefined
// until loaded.
module knapsack_selection_evaluator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [kse_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [kse_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   kse_req_if.sink                               req_bus,
   kse_rsp_if.source                             rsp_bus
);

   kse_pkg::state_type                    state_ff, state_in;
   logic [kse_pkg::COUNT_REG_BITS-1:0]    item_count_ff;
   logic [kse_pkg::LIMIT_BITS-1:0]        weight_limit_ff;
   logic [kse_pkg::LIMIT_BITS-1:0]        volume_limit_ff;

   logic [kse_pkg::CNT_BITS-1:0]          idx_ff, idx_in;
   logic [kse_pkg::CNT_BITS-1:0]          count_ff, count_in;
   logic [kse_pkg::MAX_ITEMS-1:0]         mask_ff, mask_in;
   logic                                  rd_vld_ff, rd_vld_in;
   logic                                  sel_ff, sel_in;

   logic [kse_pkg::SUM_BITS-1:0]          sum_weight_ff, sum_weight_in;
   logic [kse_pkg::SUM_BITS-1:0]          sum_volume_ff, sum_volume_in;
   logic [kse_pkg::SUM_BITS-1:0]          sum_value_ff, sum_value_in;
   logic [kse_pkg::GROUP_MAP_BITS-1:0]    present_ff, present_in;
   logic [kse_pkg::GROUP_MAP_BITS-1:0]    needed_ff, needed_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  feasible_ff, feasible_in;
   logic [kse_pkg::TOTAL_BITS-1:0]        total_value_ff, total_value_in;

   logic                                  req_take;
   logic                                  load_take;
   logic                                  ram_rd_en;
   logic [kse_pkg::ENTRY_BITS-1:0]        ram_rd_data;
   kse_pkg::entry_type                    wr_entry;
   kse_pkg::entry_type                    rd_entry;
   logic [kse_pkg::CNT_BITS-1:0]          covered;
   logic [kse_pkg::GROUP_BITS-1:0]        group_below;
   logic                                  ok;

   assign req_bus.ready = (state_ff == kse_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign load_take     = req_take && (req_bus.operation == kse_pkg::OP_LOAD) &&
                          ({1'b0, req_bus.item_index} < kse_pkg::CNT_BITS'(kse_pkg::MAX_ITEMS));

   assign wr_entry.weight = req_bus.item_weight;
   assign wr_entry.volume = req_bus.item_volume;
   assign wr_entry.value  = req_bus.item_value;
   assign wr_entry.group  = req_bus.item_group;
   assign rd_entry        = kse_pkg::entry_type'(ram_rd_data);

   assign ram_rd_en = (state_ff == kse_pkg::ST_RUN);

   kse_ram #(
      .WIDTH (kse_pkg::ENTRY_BITS),
      .DEPTH (kse_pkg::MAX_ITEMS)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_take),
      .wr_addr (req_bus.item_index),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[kse_pkg::IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (item_count_ff > kse_pkg::COUNT_REG_BITS'(kse_pkg::MAX_ITEMS)) begin
         covered = kse_pkg::CNT_BITS'(kse_pkg::MAX_ITEMS);
      end else begin
         covered = kse_pkg::CNT_BITS'(item_count_ff);
      end
   end

   assign group_below = rd_entry.group - kse_pkg::GROUP_BITS'(1);
   assign ok = ((needed_ff & ~present_ff) == '0) &&
               (sum_weight_ff <= kse_pkg::SUM_BITS'(weight_limit_ff)) &&
               (sum_volume_ff <= kse_pkg::SUM_BITS'(volume_limit_ff));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      mask_in        = mask_ff;
      rd_vld_in      = 1'b0;
      sel_in         = sel_ff;
      sum_weight_in  = sum_weight_ff;
      sum_volume_in  = sum_volume_ff;
      sum_value_in   = sum_value_ff;
      present_in     = present_ff;
      needed_in      = needed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      feasible_in    = feasible_ff;
      total_value_in = total_value_ff;

      if (rd_vld_ff && sel_ff) begin
         sum_weight_in = sum_weight_ff + kse_pkg::SUM_BITS'(rd_entry.weight);
         sum_volume_in = sum_volume_ff + kse_pkg::SUM_BITS'(rd_entry.volume);
         sum_value_in  = sum_value_ff + kse_pkg::SUM_BITS'(rd_entry.value);
         present_in    = present_ff | (kse_pkg::GROUP_MAP_BITS'(1) << rd_entry.group);
         if (rd_entry.group != '0) begin
            needed_in = needed_ff | (kse_pkg::GROUP_MAP_BITS'(1) << group_below);
         end
      end

      unique case (state_ff)
         kse_pkg::ST_IDLE: begin
            if (req_take && (req_bus.operation == kse_pkg::OP_EVALUATE)) begin
               idx_in        = '0;
               count_in      = covered;
               mask_in       = req_bus.selection_mask;
               sum_weight_in = '0;
               sum_volume_in = '0;
               sum_value_in  = '0;
               present_in    = '0;
               needed_in     = '0;
               if (covered == '0) begin
                  state_in = kse_pkg::ST_FINISH;
               end else begin
                  state_in = kse_pkg::ST_RUN;
               end
            end
         end
         kse_pkg::ST_RUN: begin
            rd_vld_in = 1'b1;
            sel_in    = mask_ff[0];
            mask_in   = mask_ff >> 1;
            idx_in    = idx_ff + kse_pkg::CNT_BITS'(1);
            if (idx_in == count_ff) begin
               state_in = kse_pkg::ST_FINISH;
            end
         end
         kse_pkg::ST_FINISH: begin
            if (!rd_vld_ff && (!rsp_valid_ff || rsp_bus.ready)) begin
               rsp_valid_in   = 1'b1;
               feasible_in    = ok;
               total_value_in = ok ? kse_pkg::TOTAL_BITS'(sum_value_ff) : '0;
               state_in       = kse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= kse_pkg::ST_IDLE;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         item_count_ff   <= kse_pkg::COUNT_REG_BITS'(1);
         weight_limit_ff <= '0;
         volume_limit_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               kse_pkg::CSR_ITEM_COUNT: begin
                  item_count_ff <= csr_write_data[kse_pkg::COUNT_REG_BITS-1:0];
               end
               kse_pkg::CSR_WEIGHT_LIMIT: begin
                  weight_limit_ff <= csr_write_data[kse_pkg::LIMIT_BITS-1:0];
               end
               kse_pkg::CSR_VOLUME_LIMIT: begin
                  volume_limit_ff <= csr_write_data[kse_pkg::LIMIT_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      count_ff       <= count_in;
      mask_ff        <= mask_in;
      sel_ff         <= sel_in;
      sum_weight_ff  <= sum_weight_in;
      sum_volume_ff  <= sum_volume_in;
      sum_value_ff   <= sum_value_in;
      present_ff     <= present_in;
      needed_ff      <= needed_in;
      feasible_ff    <= feasible_in;
      total_value_ff <= total_value_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.feasible    = feasible_ff;
   assign rsp_bus.total_value = total_value_ff;

endmodule

>>> rtl/core/kse_ram.sv
module kse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
